// ===== hw/rtl/dwpi_pkg.sv =====
// ----------------------------------------------------------------------------
// dwpi_pkg
// Shared constants, widths, register codes and types for the two-wheel
// PI speed controller.
// ----------------------------------------------------------------------------
package dwpi_pkg;

  // Moving-average depth and PWM full-scale count
  localparam int AVG_TAPS = 5;
  localparam int PWM_FULL = 255;

  localparam int SLOT_W = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int SUM_W  = 16 + SLOT_W;          // sum of all taps, signed
  localparam int Y_W    = SUM_W + 1;            // offset numerator, unsigned
  localparam int AVG_DIV   = 2 * AVG_TAPS;
  localparam int AVG_SHIFT = Y_W + 6;
  localparam longint AVG_RECIP = ((64'd1 << AVG_SHIFT) + AVG_DIV - 1) / AVG_DIV;
  localparam longint Y_OFF     = AVG_DIV * 32768;

  // Shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int ERR_W    = 18;                 // setpoint minus filtered speed
  localparam int VOLT_W   = 52;                 // drive, Q.32 volts
  localparam int VCLAMP_W = 37;                 // drive after clamp, unsigned
  localparam int PWM_W    = $clog2(PWM_FULL + 1);
  localparam int NUM_W    = VCLAMP_W + PWM_W - 20;
  localparam int QUO_W    = PWM_W;
  localparam int CNT_W    = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  // Configuration port
  localparam int APB_AW = 5;
  localparam logic [2:0] REG_KP          = 3'd0;
  localparam logic [2:0] REG_KI          = 3'd1;
  localparam logic [2:0] REG_COUNT_GAIN  = 3'd2;
  localparam logic [2:0] REG_PERIOD_GAIN = 3'd3;
  localparam logic [2:0] REG_DEAD_ZONE   = 3'd4;
  localparam logic [2:0] REG_VOLT_MAX    = 3'd5;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] count_gain;
    logic [15:0] period_gain;
    logic [15:0] dead_zone;
    logic [15:0] volt_max;
  } cfg_t;

endpackage

// ===== hw/rtl/dwpi_cfg.sv =====
// ----------------------------------------------------------------------------
// dwpi_cfg
// APB register file holding the controller gains and limits.
// ----------------------------------------------------------------------------
module dwpi_cfg import dwpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [APB_AW-1:0] addr_i,
  input  logic [31:0]       wdata_i,
  output logic [31:0]       rdata_o,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (addr_i[4:2])
        REG_KP:          cfg_d.kp          = wdata_i[15:0];
        REG_KI:          cfg_d.ki          = wdata_i[15:0];
        REG_COUNT_GAIN:  cfg_d.count_gain  = wdata_i[15:0];
        REG_PERIOD_GAIN: cfg_d.period_gain = wdata_i[15:0];
        REG_DEAD_ZONE:   cfg_d.dead_zone   = wdata_i[15:0];
        REG_VOLT_MAX:    cfg_d.volt_max    = wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp          <= 16'd4096;
      cfg_q.ki          <= 16'd4096;
      cfg_q.count_gain  <= 16'd8685;
      cfg_q.period_gain <= 16'd328;
      cfg_q.dead_zone   <= 16'd20480;
      cfg_q.volt_max    <= 16'd49152;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (addr_i[4:2])
      REG_KP:          rdata_o = {16'b0, cfg_q.kp};
      REG_KI:          rdata_o = {16'b0, cfg_q.ki};
      REG_COUNT_GAIN:  rdata_o = {16'b0, cfg_q.count_gain};
      REG_PERIOD_GAIN: rdata_o = {16'b0, cfg_q.period_gain};
      REG_DEAD_ZONE:   rdata_o = {16'b0, cfg_q.dead_zone};
      REG_VOLT_MAX:    rdata_o = {16'b0, cfg_q.volt_max};
      default:         rdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/dwpi_mul.sv =====
// ----------------------------------------------------------------------------
// dwpi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dwpi_mul import dwpi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/dwpi_div.sv =====
// ----------------------------------------------------------------------------
// dwpi_div
// Restoring divider, one quotient bit per cycle, for the PWM duty scaling.
// The quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module dwpi_div import dwpi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [15:0]      den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [15:0]      den_q;
  logic [NUM_W-1:0] shifted;

  assign shifted = NUM_W'(den_q) << cnt_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W - 1);
      rem_d  = num_i;
      quo_d  = '0;
    end else if (busy_q) begin
      if (rem_q >= shifted) begin
        rem_d        = rem_q - shifted;
        quo_d[cnt_q] = 1'b1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/dual_wheel_speed_pi_controller.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_speed_pi_controller
// Two-wheel PI speed controller with a moving-average speed filter.
//
// Usage:
// - s_axis carries one control period: encoder count changes and speed
//   setpoints for wheels A and B. m_axis returns one result per period:
//   the PWM duty and filtered speed of each wheel.
// - Both wheels run through one shared multiplier and one bit-serial
//   divider under a sequencer. A wheel takes 10 sequencer steps and a
//   wait on the divider; the next input is taken only once both wheels
//   are done and the result is in the output register, so items do not
//   overlap.
// - s_axis_tready is high only while the sequencer is idle.
// - A finished result sits in the output register; the sequencer can take
//   and work on the next item meanwhile, and only waits before loading
//   its own result if the previous one has still not been taken.
// - Reset clears the speed history, integrals and history slot and loads
//   default gains. The user must write APB registers only while idle; unenforced.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pi_controller import dwpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,  // delta_a, delta_b, setpoint_a, setpoint_b
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // pwm_a, pwm_b, speed_a, speed_b
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // sequencer steps; ST_MCNT to ST_DIV run once per wheel pass
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MCNT  = 4'd1;   // count change times count gain
  localparam logic [3:0] ST_HIST  = 4'd2;   // round speed, write history, sum
  localparam logic [3:0] ST_MAVG  = 4'd3;   // doubled sum times reciprocal of twice the tap count
  localparam logic [3:0] ST_FILT  = 4'd4;   // filtered speed and error
  localparam logic [3:0] ST_MPG   = 4'd5;   // error times period
  localparam logic [3:0] ST_INTEG = 4'd6;   // integral update, error times kp
  localparam logic [3:0] ST_MKI   = 4'd7;   // ki times integral
  localparam logic [3:0] ST_SUM   = 4'd8;   // drive sum
  localparam logic [3:0] ST_CLAMP = 4'd9;   // dead zone and clamp
  localparam logic [3:0] ST_SCALE = 4'd10;  // scale to PWM counts, start divide
  localparam logic [3:0] ST_DIV   = 4'd11;  // wait for divider
  localparam logic [3:0] ST_OUT   = 4'd12;  // load output register

  cfg_t cfg;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  dwpi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_wr),
    .addr_i  (paddr),
    .wdata_i (pwdata),
    .rdata_o (prdata),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [3:0]        state_q, state_d;
  logic              w_q, w_d;                 // wheel being worked on
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              m_valid_q, m_valid_d;

  logic signed [15:0] hist_q [2][AVG_TAPS];
  logic signed [31:0] integ_q [2];

  // per-item payload
  logic signed [9:0]        delta_q [2];
  logic [9:0]               setp_q [2];
  logic [Y_W-1:0]           y_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [VOLT_W-1:0] acc_q;
  logic signed [VOLT_W-1:0] volt_q;
  logic [VCLAMP_W-1:0]      vclamp_q;
  logic [15:0]              spd_q [2];
  logic [7:0]               duty_q [2];
  logic [47:0]              m_data_q;

  logic in_xfer, out_load;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // --------------------------------------------------------------------------
  // Shared multiplier and operand select
  // --------------------------------------------------------------------------
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_MCNT: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(delta_q[w_q]);
        mul_b  = $signed({{(MUL_W-16){1'b0}}, cfg.count_gain});
      end
      ST_MAVG: begin
        mul_en = 1'b1;
        mul_a  = $signed({{(MUL_W-Y_W){1'b0}}, y_q});
        mul_b  = MUL_W'(AVG_RECIP);
      end
      ST_MPG: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(err_q);
        mul_b  = $signed({{(MUL_W-16){1'b0}}, cfg.period_gain});
      end
      ST_INTEG: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(err_q);
        mul_b  = $signed({{(MUL_W-16){1'b0}}, cfg.kp});
      end
      ST_MKI: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(integ_q[w_q]);
        mul_b  = $signed({{(MUL_W-16){1'b0}}, cfg.ki});
      end
      default: ;
    endcase
  end

  dwpi_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // --------------------------------------------------------------------------
  // Datapath between multiplies
  // --------------------------------------------------------------------------
  // speed from counts: round Q.16 to Q8.8, saturate to 16 bits
  logic signed [25:0] cnt_rnd;
  logic signed [17:0] om_hi;
  logic signed [15:0] omega;

  assign cnt_rnd = $signed(prod[25:0]) + 26'sd128;
  assign om_hi   = cnt_rnd[25:8];

  always_comb begin
    if (om_hi[17:15] == 3'b000 || om_hi[17:15] == 3'b111) begin
      omega = om_hi[15:0];
    end else if (om_hi[17]) begin
      omega = 16'sh8000;
    end else begin
      omega = 16'sh7fff;
    end
  end

  // history sum with the new speed in place of the slot being overwritten
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W:0]   sum2;
  logic signed [SUM_W+1:0] y_full;

  always_comb begin
    sum = '0;
    for (int i = 0; i < AVG_TAPS; i++) begin
      if (slot_q == SLOT_W'(i)) begin
        sum = sum + SUM_W'(omega);
      end else begin
        sum = sum + SUM_W'(hist_q[w_q][i]);
      end
    end
  end

  // 2*sum + taps, offset so the floor divide sees a positive numerator
  assign sum2   = {sum, 1'b0};
  assign y_full = (SUM_W+2)'(sum2) + (SUM_W+2)'(AVG_TAPS + Y_OFF);

  // quotient minus the offset of 32768
  logic [15:0]             avg_q16;
  logic signed [15:0]      filt;
  logic signed [ERR_W-1:0] err_d;

  assign avg_q16 = prod[AVG_SHIFT+15:AVG_SHIFT];
  assign filt    = {~avg_q16[15], avg_q16[14:0]};
  assign err_d   = $signed({{(ERR_W-10){1'b0}}, setp_q[w_q]}) - ERR_W'(filt);

  // saturating integral
  logic signed [34:0] isum;
  logic signed [31:0] integ_d;

  assign isum = 35'(integ_q[w_q]) + 35'($signed(prod[33:0]));

  always_comb begin
    if (isum[34:31] == 4'b0000 || isum[34:31] == 4'b1111) begin
      integ_d = isum[31:0];
    end else if (isum[34]) begin
      integ_d = 32'sh8000_0000;
    end else begin
      integ_d = 32'sh7fff_ffff;
    end
  end

  // dead zone on a positive drive, clamp to the supply
  logic signed [VOLT_W-1:0] vmax;
  logic signed [VOLT_W-1:0] vz;
  logic                     v_pos;
  logic [VCLAMP_W-1:0]      vclamp_d;

  assign vmax  = $signed(VOLT_W'({cfg.volt_max, 20'b0}));
  assign vz    = volt_q + $signed(VOLT_W'({cfg.dead_zone, 20'b0}));
  assign v_pos = !volt_q[VOLT_W-1] && (volt_q != '0);

  always_comb begin
    if (!v_pos) begin
      vclamp_d = '0;
    end else if (vz > vmax) begin
      vclamp_d = vmax[VCLAMP_W-1:0];
    end else begin
      vclamp_d = vz[VCLAMP_W-1:0];
    end
  end

  // duty = floor(drive * full / (volt_max << 20)); the low 20 bits of the
  // scaled drive are dropped first, which gives the same floor
  logic [VCLAMP_W+PWM_W-1:0] scaled;
  logic [NUM_W-1:0]          div_num;
  logic                      div_busy, div_done;
  logic [QUO_W-1:0]          div_quo;
  logic [7:0]                duty_d;

  assign scaled  = (VCLAMP_W+PWM_W)'(vclamp_q) * (VCLAMP_W+PWM_W)'(PWM_FULL);
  assign div_num = scaled[VCLAMP_W+PWM_W-1:20];

  dwpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_SCALE),
    .num_i   (div_num),
    .den_i   (cfg.volt_max),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    if (cfg.volt_max == '0) begin
      duty_d = '0;
    end else if (32'(div_quo) > 32'd255) begin
      duty_d = 8'hff;
    end else begin
      duty_d = 8'(div_quo);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    slot_d    = slot_q;
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_MCNT;
          w_d     = 1'b0;
        end
      end
      ST_MCNT:  state_d = ST_HIST;
      ST_HIST:  state_d = ST_MAVG;
      ST_MAVG:  state_d = ST_FILT;
      ST_FILT:  state_d = ST_MPG;
      ST_MPG:   state_d = ST_INTEG;
      ST_INTEG: state_d = ST_MKI;
      ST_MKI:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (w_q) begin
            state_d = ST_OUT;
          end else begin
            w_d     = 1'b1;
            state_d = ST_MCNT;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
          slot_d    = (32'(slot_q) >= AVG_TAPS - 1) ? '0 : slot_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      w_q       <= 1'b0;
      slot_q    <= '0;
      m_valid_q <= 1'b0;
      for (int w = 0; w < 2; w++) begin
        integ_q[w] <= '0;
        for (int i = 0; i < AVG_TAPS; i++) begin
          hist_q[w][i] <= '0;
        end
      end
    end else begin
      state_q   <= state_d;
      w_q       <= w_d;
      slot_q    <= slot_d;
      m_valid_q <= m_valid_d;
      if (state_q == ST_HIST) begin
        for (int i = 0; i < AVG_TAPS; i++) begin
          if (slot_q == SLOT_W'(i)) begin
            hist_q[w_q][i] <= omega;
          end
        end
      end
      if (state_q == ST_INTEG) begin
        integ_q[w_q] <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      delta_q[0] <= s_axis_tdata[9:0];
      delta_q[1] <= s_axis_tdata[19:10];
      setp_q[0]  <= s_axis_tdata[29:20];
      setp_q[1]  <= s_axis_tdata[39:30];
    end
    if (state_q == ST_HIST) begin
      y_q <= y_full[Y_W-1:0];
    end
    if (state_q == ST_FILT) begin
      spd_q[w_q] <= filt;
      err_q      <= err_d;
    end
    if (state_q == ST_MKI) begin
      acc_q <= VOLT_W'($signed(prod[33:0])) <<< 16;
    end
    if (state_q == ST_SUM) begin
      volt_q <= acc_q + VOLT_W'($signed(prod[47:0]));
    end
    if (state_q == ST_CLAMP) begin
      vclamp_q <= vclamp_d;
    end
    if (state_q == ST_DIV && div_done) begin
      duty_q[w_q] <= duty_d;
    end
    if (out_load) begin
      m_data_q <= {spd_q[1], spd_q[0], duty_q[1], duty_q[0]};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < AVG_TAPS)
    else $error("history slot out of range");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide step");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("result load did not present a transfer");

endmodule

// ===== tb/dual_wheel_speed_pi_controller_tb.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_speed_pi_controller_tb
// Self-checking bench for the two-wheel PI speed controller. Control periods
// go in on s_axis; a cycle-free model of the filter and PI law predicts the
// duty and filtered speed of each wheel, and every m_axis transfer is checked
// against the oldest prediction. Gains are changed over APB between phases
// and read back. Both stream sides idle at random, with one phase of
// back-pressure that fills the block and one phase with no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dual_wheel_speed_pi_controller_tb;
  import dwpi_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400000;  // watchdog bound on the whole run
  localparam int SETTLE      = 60;      // margin longer than the block latency
  localparam int IDLE_PCT    = 21;

  // Int32 bounds of the saturating integrators
  localparam longint INTEG_MIN = -(64'sd1 <<< 31);
  localparam longint INTEG_MAX = (64'sd1 <<< 31) - 64'sd1;

  // One expected m_axis transfer
  typedef struct packed {
    logic [7:0]         pwm_a;
    logic [7:0]         pwm_b;
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
  } wheel_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata;   // delta_a, delta_b, setpoint_a, setpoint_b
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [47:0]       m_axis_tdata;   // pwm_a, pwm_b, speed_a, speed_b
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  dual_wheel_speed_pi_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Controller model state: gains, speed history per wheel, integrators
  // --------------------------------------------------------------------------
  cfg_t                  gains;
  logic signed [15:0]    speed_hist [2][AVG_TAPS];
  logic signed [31:0]    integ_acc  [2];
  int                    hist_slot;

  wheel_result_t         pending_results[$];
  int                    error_count;
  int                    cycle_count;
  bit                    no_idle;      // sender and receiver never pause
  int                    hold_req;     // receiver hold-off request, in cycles

  // --------------------------------------------------------------------------
  // Clock and cycle watchdog
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model arithmetic
  // --------------------------------------------------------------------------
  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Divisor is always positive here; rounds toward -infinity
  function automatic longint div_floor(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic void reset_controller_model();
    gains = '{kp: 16'd4096, ki: 16'd4096, count_gain: 16'd8685,
              period_gain: 16'd328, dead_zone: 16'd20480, volt_max: 16'd49152};
    for (int w = 0; w < 2; w++) begin
      integ_acc[w] = '0;
      for (int i = 0; i < AVG_TAPS; i++) speed_hist[w][i] = '0;
    end
    hist_slot = 0;
  endfunction

  // One wheel for one period: count-to-speed, moving average, PI, clamp, duty
  function automatic void wheel_period(input int w, input logic [9:0] delta_raw,
                                       input logic [9:0] setp_raw,
                                       output logic [7:0] duty_o,
                                       output logic signed [15:0] speed_o);
    longint delta, setp, omega, total, filt, err, acc, volts, vmax, duty;
    delta = longint'($signed(delta_raw));
    setp  = longint'(setp_raw);
    // Q.16 product rounded half-up to Q8.8, then int16 saturation
    omega = (delta * longint'(gains.count_gain) + 128) >>> 8;
    omega = clamp(omega, -32768, 32767);
    speed_hist[w][hist_slot] = omega[15:0];
    total = 0;
    for (int i = 0; i < AVG_TAPS; i++) total += longint'(speed_hist[w][i]);
    filt = clamp(div_floor(2 * total + AVG_TAPS, 2 * AVG_TAPS), -32768, 32767);

    err = setp - filt;
    acc = longint'(integ_acc[w]) + err * longint'(gains.period_gain);
    integ_acc[w] = 32'(clamp(acc, INTEG_MIN, INTEG_MAX));

    volts = err * longint'(gains.kp) * 65536 + longint'(gains.ki) * longint'(integ_acc[w]);
    vmax  = longint'(gains.volt_max) * 1048576;
    if (volts > 0) begin
      volts += longint'(gains.dead_zone) * 1048576;
      if (volts > vmax) volts = vmax;
    end else begin
      volts = 0;
    end
    if (vmax == 0) duty = 0;
    else duty = clamp((volts * PWM_FULL) / vmax, 0, PWM_FULL);
    if (duty > 255) duty = 255;
    duty_o  = duty[7:0];
    speed_o = filt[15:0];
  endfunction

  function automatic wheel_result_t predict_period(logic [39:0] item);
    wheel_result_t r;
    wheel_period(0, item[9:0],   item[29:20], r.pwm_a, r.speed_a);
    wheel_period(1, item[19:10], item[39:30], r.pwm_b, r.speed_b);
    hist_slot = (hist_slot + 1) % AVG_TAPS;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every m_axis transfer against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic flag_error(string what, longint exp_v, longint act_v);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    wheel_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_error("unexpected result transfer, pending count", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.pwm_a)
          flag_error("pwm_a", want.pwm_a, m_axis_tdata[7:0]);
        if (m_axis_tdata[15:8] !== want.pwm_b)
          flag_error("pwm_b", want.pwm_b, m_axis_tdata[15:8]);
        if (m_axis_tdata[31:16] !== want.speed_a)
          flag_error("speed_a", want.speed_a, $signed(m_axis_tdata[31:16]));
        if (m_axis_tdata[47:32] !== want.speed_b)
          flag_error("speed_b", want.speed_b, $signed(m_axis_tdata[47:32]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, always ready in the no-idle phase, or a counted hold-off when one is requested
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // One control period. Called at a falling edge, returns at a falling edge
  // with tvalid still high so back-to-back transfers need no gap.
  task automatic send_period(logic [9:0] delta_a, logic [9:0] delta_b,
                             logic [9:0] setp_a, logic [9:0] setp_b);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {setp_b, setp_a, delta_b, delta_a};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_period(s_axis_tdata));
    @(negedge clk_i);
  endtask

  // Drop tvalid and let every outstanding result come back
  task automatic drain_block();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Register write (setup + access), then read back through prdata
  task automatic write_gain(logic [2:0] idx, logic [15:0] value);
    paddr   = {idx, 2'b00};
    pwdata  = {16'h0, value};
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_KP:          gains.kp          = value;
      REG_KI:          gains.ki          = value;
      REG_COUNT_GAIN:  gains.count_gain  = value;
      REG_PERIOD_GAIN: gains.period_gain = value;
      REG_DEAD_ZONE:   gains.dead_zone   = value;
      REG_VOLT_MAX:    gains.volt_max    = value;
      default: ;
    endcase
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== value)
      flag_error($sformatf("read back of register %0d", idx), value, prdata[15:0]);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] cg,
                            logic [15:0] pg, logic [15:0] dz, logic [15:0] vm);
    write_gain(REG_KP, kp);
    write_gain(REG_KI, ki);
    write_gain(REG_COUNT_GAIN, cg);
    write_gain(REG_PERIOD_GAIN, pg);
    write_gain(REG_DEAD_ZONE, dz);
    write_gain(REG_VOLT_MAX, vm);
  endtask

  // Extremes one time in five, small values three in ten, full-range values half
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return 16'($urandom_range(1023));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly plausible plant behavior, plus full-range noise and near-zero
  task automatic send_random_period();
    logic [9:0] da, db, sa, sb;
    int mode;
    mode = $urandom_range(99);
    if (mode < 60) begin
      da = 10'($urandom_range(35) - 5);
      db = 10'($urandom_range(35) - 5);
      sa = 10'($urandom_range(794));
      sb = 10'($urandom_range(794));
    end else if (mode < 85) begin
      {sb, sa, db, da} = 40'({$urandom, $urandom});
    end else begin
      da = 10'($urandom_range(4) - 2);
      db = 10'($urandom_range(4) - 2);
      sa = 10'($urandom_range(40));
      sb = 10'($urandom_range(40));
    end
    send_period(da, db, sa, sb);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset gains: field extremes, setpoints past the nominal range
  task automatic test_reset_gains();
    send_period(10'd0,    10'd0,    10'd0,    10'd0);
    send_period(10'd511,  -10'sd512, 10'd794, 10'd794);
    send_period(-10'sd512, 10'd511, 10'd0,    10'd794);
    send_period(10'd511,  10'd511,  10'd1023, 10'd1023);
    send_period(-10'sd512, -10'sd512, 10'd1023, 10'd0);
    send_period(10'd1,    -10'sd1,  10'd1,    10'd1);
    send_period(10'd6,    10'd6,    10'd200,  10'd200);
    send_period(10'd6,    10'd6,    10'd200,  10'd200);
    send_period(10'd0,    10'd0,    10'd794,  10'd0);
    drain_block();
  endtask

  // All gains at maximum: per-period speed overflow and integrator limits
  // in both directions
  task automatic test_gain_saturation();
    load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (4) send_period(10'd511, -10'sd512, 10'd0, 10'd1023);
    repeat (4) send_period(-10'sd512, 10'd511, 10'd1023, 10'd0);
    drain_block();
  endtask

  // Zero supply voltage: drive clamps to 0 V and duty is 0
  task automatic test_zero_supply();
    load_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_period(10'd100, -10'sd100, 10'd794, 10'd0);
    send_period(10'd0, 10'd0, 10'd1023, 10'd1023);
    drain_block();
    write_gain(REG_KP, 16'hFFFF);   // positive drive, still nothing to scale by
    send_period(-10'sd512, 10'd511, 10'd500, 10'd500);
    send_period(10'd0, 10'd0, 10'd794, 10'd794);
    drain_block();
  endtask

  // Several gain sets; the first is the power-on set written explicitly
  task automatic test_random_gains(int phases, int per_phase);
    logic [15:0] vm;
    for (int p = 0; p < phases; p++) begin
      if (p == 0) begin
        load_gains(16'd4096, 16'd4096, 16'd8685, 16'd328, 16'd20480, 16'd49152);
      end else begin
        vm = pick_gain();
        if (vm == 16'h0) vm = 16'h1;
        load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(), vm);
      end
      repeat (per_phase) send_random_period();
      drain_block();
    end
  endtask

  // Result side holds off for a long stretch while periods keep coming, so
  // the output register and the sequencer both fill and tready drops
  task automatic test_output_backpressure();
    load_gains(16'd2048, 16'd512, 16'd8685, 16'd328, 16'd4096, 16'd49152);
    hold_req = 400;
    repeat (30) send_random_period();
    drain_block();
  endtask

  // Periods offered back to back with no idling on either side
  task automatic test_full_rate();
    no_idle = 1'b1;
    repeat (150) send_random_period();
    drain_block();
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    error_count   = 0;
    cycle_count   = 0;
    no_idle       = 1'b0;
    hold_req      = 0;
    reset_controller_model();

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (5) @(negedge clk_i);

    test_reset_gains();
    test_gain_saturation();
    test_zero_supply();
    test_random_gains(4, 150);
    test_output_backpressure();
    test_full_rate();

    // drain_block already waited out the latency after the last result
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dwpi_pkg.sv
hw/rtl/dwpi_cfg.sv
hw/rtl/dwpi_mul.sv
hw/rtl/dwpi_div.sv
hw/rtl/dual_wheel_speed_pi_controller.sv
tb/dual_wheel_speed_pi_controller_tb.sv
